/* sv/dmx_pkg.sv */
`timescale 1ns / 1ps

package dmx_pkg;

    localparam int FRAME_BYTES = 513;
    localparam int ADDR_W      = $clog2(FRAME_BYTES);
    localparam int SLOT_W      = $clog2(FRAME_BYTES + 1);
    localparam int CMP_W       = (SLOT_W > 10) ? SLOT_W : 10;

    localparam logic [ADDR_W-1:0] LAST_ADDR       = ADDR_W'(FRAME_BYTES - 1);
    localparam logic [9:0]        MIN_SLOTS_RESET = 10'd24;
    localparam logic [9:0]        PUB_SLOTS_RESET = 10'(FRAME_BYTES - 1);

    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_BREAK = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ARMED,
        PH_RECV
    } phase_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_COPY
    } state_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
        logic [9:0] channel;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       read_out_of_range;
        logic       frame_published;
        logic [9:0] slot_count;
    } result_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

/* sv/dmx512_frame_receiver.sv */
`timescale 1ns / 1ps

// channel   signals                       direction  handshake
// command   start, item                   in         start && !busy
// result    done, result                  out        done for one cycle
// config    cfg_we, cfg_data (min_slots)  in         cfg_we
//
// byte and break beats give their result in the cycle after acceptance, reads in
// range pass through ST_READ first (registered read of the published store)
// a publishing beat copies n received bytes over the store port in ST_COPY
// after reset the published store is zeroed, one entry a cycle, all 513 entries while busy
// results cannot be stalled; busy is low whenever the controller is idle

module dmx512_frame_receiver (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  dmx_pkg::item_t   item,
    output logic             busy,
    output logic             done,
    output dmx_pkg::result_t result,
    input  logic             cfg_we,
    input  logic [9:0]       cfg_data
);

    dmx_pkg::mem_req_t rb_req;
    dmx_pkg::mem_req_t pb_req;
    logic [7:0]        rb_rdata;
    logic [7:0]        pb_rdata;

    dmx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .item     (item),
        .busy     (busy),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .rb_req   (rb_req),
        .rb_rdata (rb_rdata),
        .pb_req   (pb_req),
        .pb_rdata (pb_rdata)
    );

    dmx_ram #(
        .DEPTH (dmx_pkg::FRAME_BYTES),
        .WIDTH (8),
        .AW    (dmx_pkg::ADDR_W)
    ) u_rx_ram (
        .clk   (clk),
        .we    (rb_req.we),
        .waddr (rb_req.waddr),
        .wdata (rb_req.wdata),
        .raddr (rb_req.raddr),
        .rdata (rb_rdata)
    );

    dmx_ram #(
        .DEPTH (dmx_pkg::FRAME_BYTES),
        .WIDTH (8),
        .AW    (dmx_pkg::ADDR_W)
    ) u_pub_ram (
        .clk   (clk),
        .we    (pb_req.we),
        .waddr (pb_req.waddr),
        .wdata (pb_req.wdata),
        .raddr (pb_req.raddr),
        .rdata (pb_rdata)
    );

endmodule

/* sv/dmx_ram.sv */
`timescale 1ns / 1ps

module dmx_ram #(
    parameter int DEPTH = 513,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        q_reg <= mem[raddr];
    end

    assign rdata = q_reg;

endmodule

/* sv/dmx_ctrl.sv */
`timescale 1ns / 1ps

module dmx_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  dmx_pkg::item_t    item,
    output logic              busy,
    output logic              done,
    output dmx_pkg::result_t  result,
    input  logic              cfg_we,
    input  logic [9:0]        cfg_data,
    output dmx_pkg::mem_req_t rb_req,
    input  logic [7:0]        rb_rdata,
    output dmx_pkg::mem_req_t pb_req,
    input  logic [7:0]        pb_rdata
);

    dmx_pkg::state_t  state_reg, state_next;
    dmx_pkg::phase_t  phase_reg, phase_next;
    logic [dmx_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [dmx_pkg::SLOT_W-1:0] cnt_reg, cnt_next;
    logic [dmx_pkg::SLOT_W-1:0] len_reg, len_next;
    logic [dmx_pkg::ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    logic                       wr_valid_reg, wr_valid_next;
    logic                       sc_nz_reg, sc_nz_next;
    logic [9:0]                 min_reg, min_next;
    logic [9:0]                 pub_slots_reg, pub_slots_next;
    logic                       done_reg, done_next;
    dmx_pkg::result_t           out_reg, out_next;

    logic [dmx_pkg::SLOT_W-1:0] slot_inc;
    logic [dmx_pkg::SLOT_W-1:0] pub_len;
    logic                       do_pub;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dmx_pkg::ST_CLEAR;
            phase_reg     <= dmx_pkg::PH_IDLE;
            slot_reg      <= '0;
            cnt_reg       <= '0;
            wr_valid_reg  <= 1'b0;
            sc_nz_reg     <= 1'b0;
            min_reg       <= dmx_pkg::MIN_SLOTS_RESET;
            pub_slots_reg <= dmx_pkg::PUB_SLOTS_RESET;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            slot_reg      <= slot_next;
            cnt_reg       <= cnt_next;
            wr_valid_reg  <= wr_valid_next;
            sc_nz_reg     <= sc_nz_next;
            min_reg       <= min_next;
            pub_slots_reg <= pub_slots_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg     <= len_next;
        wr_addr_reg <= wr_addr_next;
        out_reg     <= out_next;
    end

    assign slot_inc = slot_reg + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        slot_next      = slot_reg;
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        wr_addr_next   = wr_addr_reg;
        wr_valid_next  = wr_valid_reg;
        sc_nz_next     = sc_nz_reg;
        min_next       = cfg_we ? cfg_data : min_reg;
        pub_slots_next = pub_slots_reg;
        done_next      = 1'b0;
        out_next       = out_reg;
        rb_req         = '0;
        pb_req         = '0;
        do_pub         = 1'b0;
        pub_len        = slot_reg;

        case (state_reg)
            dmx_pkg::ST_CLEAR:
            begin
                pb_req.we    = 1'b1;
                pb_req.waddr = cnt_reg[dmx_pkg::ADDR_W-1:0];
                pb_req.wdata = 8'd0;
                if (cnt_reg[dmx_pkg::ADDR_W-1:0] == dmx_pkg::LAST_ADDR)
                begin
                    cnt_next   = '0;
                    state_next = dmx_pkg::ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            dmx_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    out_next  = '{read_data: 8'd0, read_out_of_range: 1'b0,
                                  frame_published: 1'b0, slot_count: pub_slots_reg};
                    done_next = 1'b1;
                    case (item.mode)
                        dmx_pkg::MODE_BYTE:
                        begin
                            if (phase_reg == dmx_pkg::PH_RECV)
                            begin
                                rb_req.we    = slot_reg < dmx_pkg::SLOT_W'(dmx_pkg::FRAME_BYTES);
                                rb_req.waddr = slot_reg[dmx_pkg::ADDR_W-1:0];
                                rb_req.wdata = item.data_byte;
                                if (slot_reg == '0)
                                begin
                                    sc_nz_next = item.data_byte != 8'd0;
                                end
                                if (slot_reg == dmx_pkg::SLOT_W'(2) && sc_nz_reg)
                                begin
                                    phase_next = dmx_pkg::PH_IDLE;
                                end
                                slot_next = slot_inc;
                                if (slot_inc >= dmx_pkg::SLOT_W'(dmx_pkg::FRAME_BYTES))
                                begin
                                    phase_next = dmx_pkg::PH_IDLE;
                                    slot_next  = '0;
                                    pub_len    = slot_inc;
                                    do_pub     = !sc_nz_reg &&
                                                 (dmx_pkg::CMP_W'(slot_inc) >
                                                  dmx_pkg::CMP_W'(min_reg));
                                end
                            end
                            else if (phase_reg == dmx_pkg::PH_ARMED)
                            begin
                                phase_next = dmx_pkg::PH_RECV;
                            end
                        end

                        dmx_pkg::MODE_BREAK:
                        begin
                            pub_len    = slot_reg;
                            do_pub     = (phase_reg == dmx_pkg::PH_RECV) &&
                                         (slot_reg > dmx_pkg::SLOT_W'(1)) && !sc_nz_reg &&
                                         (dmx_pkg::CMP_W'(slot_reg) > dmx_pkg::CMP_W'(min_reg));
                            phase_next = dmx_pkg::PH_ARMED;
                            slot_next  = '0;
                        end

                        dmx_pkg::MODE_READ:
                        begin
                            if (dmx_pkg::CMP_W'(item.channel) <
                                dmx_pkg::CMP_W'(dmx_pkg::FRAME_BYTES))
                            begin
                                pb_req.raddr = item.channel[dmx_pkg::ADDR_W-1:0];
                                done_next    = 1'b0;
                                state_next   = dmx_pkg::ST_READ;
                            end
                            else
                            begin
                                out_next.read_out_of_range = 1'b1;
                            end
                        end

                        default:
                        begin
                        end
                    endcase

                    if (do_pub)
                    begin
                        pub_slots_next = 10'(pub_len - 1'b1);
                        len_next       = pub_len;
                        cnt_next       = '0;
                        wr_valid_next  = 1'b0;
                        done_next      = 1'b0;
                        state_next     = dmx_pkg::ST_COPY;
                    end
                end
            end

            dmx_pkg::ST_READ:
            begin
                out_next.read_data = pb_rdata;
                done_next          = 1'b1;
                state_next         = dmx_pkg::ST_IDLE;
            end

            dmx_pkg::ST_COPY:
            begin
                rb_req.raddr = cnt_reg[dmx_pkg::ADDR_W-1:0];
                pb_req.we    = wr_valid_reg;
                pb_req.waddr = wr_addr_reg;
                pb_req.wdata = rb_rdata;
                if (cnt_reg < len_reg)
                begin
                    cnt_next      = cnt_reg + 1'b1;
                    wr_valid_next = 1'b1;
                    wr_addr_next  = cnt_reg[dmx_pkg::ADDR_W-1:0];
                end
                else
                begin
                    wr_valid_next = 1'b0;
                    if (!wr_valid_reg)
                    begin
                        out_next.frame_published = 1'b1;
                        out_next.slot_count      = pub_slots_reg;
                        done_next                = 1'b1;
                        cnt_next                 = '0;
                        state_next               = dmx_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = dmx_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy   = state_reg != dmx_pkg::ST_IDLE;
    assign done   = done_reg;
    assign result = out_reg;

endmodule

/* bench/tb_dmx512_frame_receiver.sv */
`timescale 1ns / 1ps

module tb_dmx512_frame_receiver;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 600;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    dmx_pkg::item_t   item = '0;
    logic             busy;
    logic             done;
    dmx_pkg::result_t result;
    logic             cfg_we = 1'b0;
    logic [9:0]       cfg_data = '0;

    dmx_pkg::item_t   uart_events[$];
    dmx_pkg::result_t due_reports[$];

    dmx_pkg::phase_t rx_phase;
    int              rx_next;
    logic [7:0]      rx_buf [dmx_pkg::FRAME_BYTES];
    logic [7:0]      pub_buf [dmx_pkg::FRAME_BYTES];
    logic [9:0]      pub_slots;
    logic [9:0]      cfg_min;

    int idle_pct = 21;
    bit cmd_accepted = 1'b0;
    int cycle_count = 0;
    int failures = 0;
    int beats_queued = 0;
    int beats_taken = 0;
    int reads_seen = 0;
    int reads_oor = 0;
    int frames_published = 0;
    int settings_used = 0;

    dmx512_frame_receiver u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .item     (item),
        .busy     (busy),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit close_frame();
        bit published;
        published = 1'b0;
        if (rx_buf[0] == 8'd0 && rx_next > int'(cfg_min))
        begin
            for (int k = 0; k < rx_next && k < dmx_pkg::FRAME_BYTES; k++)
                pub_buf[k] = rx_buf[k];
            pub_slots = 10'(rx_next - 1);
            published = 1'b1;
        end
        rx_phase = dmx_pkg::PH_IDLE;
        rx_next = 0;
        return published;
    endfunction

    task automatic track_dmx_event(input dmx_pkg::item_t beat,
                                   output dmx_pkg::result_t rep);
        rep = '0;
        case (beat.mode)
            dmx_pkg::MODE_BYTE:
            begin
                if (rx_phase == dmx_pkg::PH_RECV)
                begin
                    if (rx_next < dmx_pkg::FRAME_BYTES)
                        rx_buf[rx_next] = beat.data_byte;
                    if (rx_next == 2 && rx_buf[0] != 8'd0)
                        rx_phase = dmx_pkg::PH_IDLE;
                    rx_next++;
                    if (rx_next >= dmx_pkg::FRAME_BYTES)
                        rep.frame_published = close_frame();
                end
                else if (rx_phase == dmx_pkg::PH_ARMED)
                begin
                    rx_phase = dmx_pkg::PH_RECV;
                end
            end
            dmx_pkg::MODE_BREAK:
            begin
                if (rx_phase == dmx_pkg::PH_RECV && rx_next > 1 && rx_buf[0] == 8'd0)
                    rep.frame_published = close_frame();
                rx_phase = dmx_pkg::PH_ARMED;
                rx_next = 0;
            end
            dmx_pkg::MODE_READ:
            begin
                if (int'(beat.channel) < dmx_pkg::FRAME_BYTES)
                    rep.read_data = pub_buf[beat.channel];
                else
                    rep.read_out_of_range = 1'b1;
            end
            default:
            begin
            end
        endcase
        rep.slot_count = pub_slots;
    endtask

    // driver: new beat or gap at each falling edge once the last one is taken
    always @(negedge clk)
    begin
        if (rst_n && (!start || cmd_accepted))
        begin
            if (uart_events.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                item <= uart_events.pop_front();
                start <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin
        dmx_pkg::result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (due_reports.size() == 0)
                begin
                    $error("result beat with nothing outstanding");
                    failures++;
                end
                else
                begin
                    want = due_reports.pop_front();
                    if (result.read_data !== want.read_data)
                    begin
                        $error("read_data expected %0d actual %0d",
                               want.read_data, result.read_data);
                        failures++;
                    end
                    if (result.read_out_of_range !== want.read_out_of_range)
                    begin
                        $error("read_out_of_range expected %0d actual %0d",
                               want.read_out_of_range, result.read_out_of_range);
                        failures++;
                    end
                    if (result.frame_published !== want.frame_published)
                    begin
                        $error("frame_published expected %0d actual %0d",
                               want.frame_published, result.frame_published);
                        failures++;
                    end
                    if (result.slot_count !== want.slot_count)
                    begin
                        $error("slot_count expected %0d actual %0d",
                               want.slot_count, result.slot_count);
                        failures++;
                    end
                end
            end
            if (cfg_we)
                cfg_min = cfg_data;
            cmd_accepted = start && !busy;
            if (cmd_accepted)
            begin
                track_dmx_event(item, want);
                due_reports.push_back(want);
                beats_taken++;
                if (item.mode == dmx_pkg::MODE_READ)
                    reads_seen++;
                if (want.read_out_of_range)
                    reads_oor++;
                if (want.frame_published)
                    frames_published++;
            end
        end
        else
        begin
            cmd_accepted = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic queue_beat(input logic [1:0] mode, input logic [7:0] data_byte,
                              input logic [9:0] channel);
        dmx_pkg::item_t beat;
        beat.mode = mode;
        beat.data_byte = data_byte;
        beat.channel = channel;
        uart_events.push_back(beat);
        beats_queued++;
    endtask

    // break, spurious byte, then start code and data slots
    task automatic queue_frame(input int n_bytes, input logic [7:0] start_code);
        queue_beat(dmx_pkg::MODE_BREAK, 8'($urandom), 10'($urandom));
        queue_beat(dmx_pkg::MODE_BYTE, 8'($urandom), 10'($urandom));
        for (int k = 0; k < n_bytes; k++)
            queue_beat(dmx_pkg::MODE_BYTE, (k == 0) ? start_code : 8'($urandom),
                       10'($urandom));
    endtask

    task automatic queue_reads(input int count, input int top);
        int r;
        int chan;
        repeat (count)
        begin
            r = $urandom_range(99);
            if (r < 70)
                chan = $urandom_range(0, top);
            else if (r < 85)
                chan = $urandom_range(505, 520);
            else
                chan = $urandom_range(0, 1023);
            queue_beat(dmx_pkg::MODE_READ, 8'($urandom), 10'(chan));
        end
    endtask

    task automatic queue_random_phase(input int budget, input int floor_slots);
        int first;
        int r;
        int n;
        int lo;
        logic [7:0] sc;
        first = beats_queued;
        while (beats_queued - first < budget)
        begin
            r = $urandom_range(99);
            if (r < 70)
            begin
                lo = (floor_slots > 2) ? floor_slots - 2 : 0;
                if (floor_slots <= 40 && $urandom_range(99) < 65)
                    n = $urandom_range(lo, floor_slots + 4);
                else
                    n = $urandom_range(0, 12);
                sc = ($urandom_range(99) < 88) ? 8'h00 : 8'($urandom_range(1, 255));
                queue_frame(n, sc);
                queue_reads($urandom_range(0, 3), 40);
            end
            else if (r < 85)
            begin
                queue_reads($urandom_range(1, 3), 40);
            end
            else
            begin
                queue_beat(2'($urandom), 8'($urandom), 10'($urandom));
            end
        end
        queue_beat(dmx_pkg::MODE_BREAK, 8'($urandom), 10'($urandom));
        queue_reads(3, 40);
    endtask

    task automatic wait_quiet();
        do
            @(negedge clk);
        while (uart_events.size() != 0 || start || due_reports.size() != 0 || busy);
    endtask

    task automatic write_min_slots(input logic [9:0] value);
        wait_quiet();
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        logic [9:0] floor_val;
        rx_phase = dmx_pkg::PH_IDLE;
        rx_next = 0;
        pub_slots = dmx_pkg::PUB_SLOTS_RESET;
        cfg_min = dmx_pkg::MIN_SLOTS_RESET;
        for (int k = 0; k < dmx_pkg::FRAME_BYTES; k++)
        begin
            rx_buf[k] = 8'd0;
            pub_buf[k] = 8'd0;
        end

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // reset contents, reads at the store edges, unused mode, byte while idle
        queue_beat(dmx_pkg::MODE_READ, 8'h00, 10'd0);
        queue_beat(dmx_pkg::MODE_READ, 8'hFF, 10'd513);
        queue_beat(dmx_pkg::MODE_READ, 8'h00, 10'd1023);
        queue_beat(MODE_UNUSED, 8'hFF, 10'h3FF);
        queue_beat(dmx_pkg::MODE_BYTE, 8'hFF, 10'd0);
        // short frame under the reset threshold
        queue_frame(2, 8'h00);
        queue_beat(dmx_pkg::MODE_BREAK, 8'h00, 10'd0);
        wait_quiet();

        write_min_slots(10'd1);
        // break after only the start code
        queue_frame(1, 8'h00);
        // nonzero start code goes idle at slot 2, later byte ignored
        queue_beat(dmx_pkg::MODE_BREAK, 8'h00, 10'd0);
        queue_beat(dmx_pkg::MODE_BYTE, 8'h12, 10'd0);
        queue_beat(dmx_pkg::MODE_BYTE, 8'h55, 10'd0);
        queue_beat(dmx_pkg::MODE_BYTE, 8'h01, 10'd0);
        queue_beat(dmx_pkg::MODE_BYTE, 8'h02, 10'd0);
        queue_beat(dmx_pkg::MODE_BYTE, 8'h03, 10'd0);
        // minimal published frame
        queue_frame(2, 8'h00);
        queue_beat(dmx_pkg::MODE_BREAK, 8'h00, 10'd0);
        queue_beat(dmx_pkg::MODE_READ, 8'h00, 10'd1);
        queue_beat(dmx_pkg::MODE_READ, 8'h00, 10'd0);

        write_min_slots(10'd0);
        queue_random_phase(140, 0);

        floor_val = 10'($urandom_range(2, 30));
        write_min_slots(floor_val);
        queue_random_phase(140, floor_val);

        // full-length frame, no idling on the command side
        write_min_slots(10'd512);
        idle_pct = 0;
        queue_frame(dmx_pkg::FRAME_BYTES, 8'h00);
        queue_beat(dmx_pkg::MODE_BYTE, 8'hA5, 10'd0);
        queue_beat(dmx_pkg::MODE_BYTE, 8'h5A, 10'd0);
        queue_reads(20, 512);
        queue_beat(dmx_pkg::MODE_BREAK, 8'h00, 10'd0);
        wait_quiet();
        idle_pct = 21;

        write_min_slots(10'd513);
        queue_random_phase(90, 513);

        floor_val = 10'($urandom_range(0, 513));
        write_min_slots(floor_val);
        queue_random_phase(90, floor_val);

        write_min_slots(10'd2);
        queue_random_phase(80, 2);

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (due_reports.size() != 0)
        begin
            $error("%0d result beats never arrived", due_reports.size());
            failures++;
        end

        $display("covered %0d uart beats over %0d min_slots settings, %0d frames published",
                 beats_taken, settings_used, frames_published);
        $display("channel reads %0d, of which %0d out of range, %0d mismatches",
                 reads_seen, reads_oor, failures);
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* dmx512_frame_receiver.f */
sv/dmx_pkg.sv
sv/dmx_ram.sv
sv/dmx_ctrl.sv
sv/dmx512_frame_receiver.sv
bench/tb_dmx512_frame_receiver.sv
